[design/tec_pkg.sv]
package tec_pkg;

  // Length counter width and its saturation value.
  localparam int LEN_BITS = 20;
  localparam logic [LEN_BITS-1:0] LEN_MASK = {LEN_BITS{1'b1}};

  // Result codes.
  localparam logic [2:0] TYPE_ASCII   = 3'd0;
  localparam logic [2:0] TYPE_UTF8    = 3'd1;
  localparam logic [2:0] TYPE_UTF16LE = 3'd2;
  localparam logic [2:0] TYPE_UTF16BE = 3'd3;
  localparam logic [2:0] TYPE_BINARY  = 3'd4;

  // UTF-16 byte order, fixed by the first two bytes.
  localparam logic [1:0] MODE_LE   = 2'd0;
  localparam logic [1:0] MODE_BE   = 2'd1;
  localparam logic [1:0] MODE_NONE = 2'd2;

  // One request moving from the input register into the scanner.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
    logic       empty;
  } step_t;

  typedef struct packed {
    logic [2:0] text_type;
    logic       too_long;
  } verdict_t;

  function automatic logic plain_text(input logic [7:0] b);
    plain_text = (b >= 8'h07 && b <= 8'h0A) || b == 8'h0C || b == 8'h0D ||
                 b == 8'h1B || (b >= 8'h20 && b <= 8'h7E) || b == 8'h85;
  endfunction

  function automatic logic never_text(input logic [7:0] b);
    never_text = (b < 8'h20 && !plain_text(b)) || b == 8'h7F;
  endfunction

endpackage

[design/tec_scan.sv]
module tec_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  tec_pkg::step_t   step,
  output tec_pkg::verdict_t verdict
);

  logic                         ascii_r, ascii_nxt;
  logic                         u8_alive_r, u8_alive_nxt;
  logic [2:0]                   u8_pend_r, u8_pend_nxt;
  logic                         u8_seen_r, u8_seen_nxt;
  logic [tec_pkg::LEN_BITS-1:0] count_r, count_nxt;
  logic [7:0]                   held_r, held_nxt;
  logic [1:0]                   mode_r, mode_nxt;
  logic                         u16_alive_r, u16_alive_nxt;
  logic [tec_pkg::LEN_BITS-1:0] bad_r, bad_nxt;
  logic                         ovf_r, ovf_nxt;

  logic       take;
  logic       close;
  logic [7:0] b;
  logic [7:0] unit_hi;
  logic [7:0] unit_lo;

  assign b     = step.data;
  assign take  = step.vld && !step.empty;
  assign close = step.vld && (step.empty || step.last);

  always_comb begin
    ascii_nxt     = ascii_r;
    u8_alive_nxt  = u8_alive_r;
    u8_pend_nxt   = u8_pend_r;
    u8_seen_nxt   = u8_seen_r;
    count_nxt     = count_r;
    held_nxt      = held_r;
    mode_nxt      = mode_r;
    u16_alive_nxt = u16_alive_r;
    bad_nxt       = bad_r;
    ovf_nxt       = ovf_r;
    if (mode_r == tec_pkg::MODE_LE) begin
      unit_hi = b;
      unit_lo = held_r;
    end else begin
      unit_hi = held_r;
      unit_lo = b;
    end

    if (take && !ovf_r) begin
      if (count_r == tec_pkg::LEN_MASK) begin
        ovf_nxt = 1'b1;
      end else begin
        if (tec_pkg::never_text(b)) begin
          ascii_nxt = 1'b0;
        end

        if (u8_alive_r) begin
          priority if (u8_pend_r != 3'd0) begin
            if (b[7:6] == 2'b10) begin
              u8_pend_nxt = u8_pend_r - 3'd1;
              if (u8_pend_r == 3'd1) begin
                u8_seen_nxt = 1'b1;
              end
            end else begin
              u8_alive_nxt = 1'b0;
            end
          end else if (!b[7]) begin
            if (!tec_pkg::plain_text(b)) begin
              u8_alive_nxt = 1'b0;
            end
          end else if (!b[6]) begin
            u8_alive_nxt = 1'b0;
          end else if (!b[5]) begin
            u8_pend_nxt = 3'd1;
          end else if (!b[4]) begin
            u8_pend_nxt = 3'd2;
          end else if (!b[3]) begin
            u8_pend_nxt = 3'd3;
          end else if (!b[2]) begin
            u8_pend_nxt = 3'd4;
          end else if (!b[1]) begin
            u8_pend_nxt = 3'd5;
          end else begin
            u8_alive_nxt = 1'b0;
          end
        end

        // Byte-order mark check on the second byte, code units after that.
        if (count_r == tec_pkg::LEN_BITS'(1)) begin
          priority if (held_r == 8'hFF && b == 8'hFE) begin
            mode_nxt = tec_pkg::MODE_LE;
          end else if (held_r == 8'hFE && b == 8'hFF) begin
            mode_nxt = tec_pkg::MODE_BE;
          end else begin
            mode_nxt = tec_pkg::MODE_NONE;
          end
        end else if (count_r[0] && u16_alive_r) begin
          if (unit_hi == 8'hFF && unit_lo == 8'hFE) begin
            u16_alive_nxt = 1'b0;
          end else if (unit_hi == 8'h00 && !unit_lo[7] && !tec_pkg::plain_text(unit_lo)) begin
            if (mode_r == tec_pkg::MODE_NONE) begin
              u16_alive_nxt = 1'b0;
            end else if (bad_r != tec_pkg::LEN_MASK) begin
              bad_nxt = bad_r + tec_pkg::LEN_BITS'(1);
            end
          end
        end

        held_nxt  = b;
        count_nxt = count_r + tec_pkg::LEN_BITS'(1);
      end
    end
  end

  // Verdict on the state including the closing byte.
  always_comb begin
    verdict.too_long = 1'b0;
    priority if (ovf_nxt) begin
      verdict.text_type = tec_pkg::TYPE_BINARY;
      verdict.too_long  = 1'b1;
    end else if (ascii_nxt) begin
      verdict.text_type = tec_pkg::TYPE_ASCII;
    end else if (u8_alive_nxt && u8_seen_nxt) begin
      verdict.text_type = tec_pkg::TYPE_UTF8;
    end else if (count_nxt >= tec_pkg::LEN_BITS'(2) && u16_alive_nxt &&
                 (mode_nxt == tec_pkg::MODE_NONE || bad_nxt < (count_nxt >> 1))) begin
      verdict.text_type = (mode_nxt == tec_pkg::MODE_LE) ? tec_pkg::TYPE_UTF16LE
                                                         : tec_pkg::TYPE_UTF16BE;
    end else begin
      verdict.text_type = tec_pkg::TYPE_BINARY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || close) begin
      ascii_r     <= 1'b1;
      u8_alive_r  <= 1'b1;
      u8_pend_r   <= 3'd0;
      u8_seen_r   <= 1'b0;
      count_r     <= '0;
      held_r      <= 8'h00;
      mode_r      <= tec_pkg::MODE_LE;
      u16_alive_r <= 1'b1;
      bad_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      ascii_r     <= ascii_nxt;
      u8_alive_r  <= u8_alive_nxt;
      u8_pend_r   <= u8_pend_nxt;
      u8_seen_r   <= u8_seen_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      mode_r      <= mode_nxt;
      u16_alive_r <= u16_alive_nxt;
      bad_r       <= bad_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

endmodule

[design/text_encoding_classifier.sv]
// Text encoding classifier.
// A buffer streams in on the in_ channel, one byte per request. in_last_byte
// marks the final byte; in_empty_buffer closes the buffer without adding the
// byte (alone it reports an empty buffer as ASCII). Exactly one request leaves
// on the out_ channel per closed buffer: out_text_type (0 ASCII, 1 UTF-8,
// 2 UTF-16 LE, 3 UTF-16 BE, 4 binary) and out_too_long, set when the buffer ran
// past the 20-bit length counter (type is then binary).
// Throughput: one byte per cycle, whatever the buffer lengths, unless a closing byte waits on out_stall.
// A closing request goes through the input register, then the result register, to out_valid.
// Datapath: input register -> scanner flags/counters plus verdict logic ->
// result register; the verdict compare of the mismatch count against half the
// length is the longest path.
// Stall: a valid result in the result register holds while out_stall is high. Bytes that do not
// close a buffer keep flowing; a closing byte waits in the input register, and
// in_stall rises only then.
// Reset (synchronous, rst_n low): both registers empty, scanner state back to
// a fresh buffer.
module text_encoding_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       in_empty_buffer,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_text_type,
  output logic       out_too_long
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       s1_empty_r;

  // result register
  logic       out_valid_r;
  logic [2:0] out_type_r;
  logic       out_long_r;

  logic              out_free;
  logic              s1_closes;
  logic              s1_move;
  logic              in_take;
  tec_pkg::step_t    step;
  tec_pkg::verdict_t verdict;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_closes = s1_last_r || s1_empty_r;
  // Non-closing bytes never wait on the result side.
  assign s1_move   = s1_valid_r && (!s1_closes || out_free);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_take   = in_valid && !in_stall;

  assign step.vld   = s1_move;
  assign step.data  = s1_data_r;
  assign step.last  = s1_last_r;
  assign step.empty = s1_empty_r;

  tec_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r  <= in_data_byte;
      s1_last_r  <= in_last_byte;
      s1_empty_r <= in_empty_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move && s1_closes) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_closes) begin
      out_type_r <= verdict.text_type;
      out_long_r <= verdict.too_long;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_type = out_type_r;
  assign out_too_long  = out_long_r;

  // A held-back request is always a closing one blocked by a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_closes && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // Every closing request that moves produces a result next cycle.
  a_close_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_closes) |=> out_valid_r)
    else $error("closing request lost its result");

  // An overlong buffer is always reported as binary.
  a_long_binary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_long_r) |-> (out_type_r == tec_pkg::TYPE_BINARY))
    else $error("too_long without binary type");

  // A result that was waiting is not overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(s1_move && s1_closes))
    else $error("result overwritten while stalled");

endmodule
